[rtl/euler_path_classifier_macros.svh]
// Assertion macros for the Euler path classifier checker.
`ifndef EULER_PATH_CLASSIFIER_MACROS_SVH
`define EULER_PATH_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define EPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define EPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/eup_pkg.sv]
// Shared constants, codes and types of the Euler path classifier.
package eup_pkg;

    // Store geometry
    localparam int MAX_VERTICES = 512;
    localparam int IDX_W        = $clog2(MAX_VERTICES);

    // Field widths
    localparam int CMD_W    = 2;
    localparam int VERTEX_W = 9;
    localparam int CLASS_W  = 2;
    localparam int DEGREE_W = 16;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_VERTEX_COUNT = '0;
    localparam logic [VERTEX_W-1:0] VCOUNT_RESET = VERTEX_W'(1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_DEGREE = 2'd2;

    // Result kinds
    localparam logic KIND_CLASS  = 1'b0;
    localparam logic KIND_DEGREE = 1'b1;

    // Graph classes
    localparam logic [CLASS_W-1:0] CLASS_NON   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SEMI  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_EULER = 2'd2;

    // One result item from the core to the output register
    typedef struct packed {
        logic                kind;
        logic [CLASS_W-1:0]  graph_class;
        logic [DEGREE_W-1:0] degree;
    } t_result;

endpackage

[rtl/eup_core.sv]
// Sequencer and the degree and parent memories of the classifier.
module eup_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [eup_pkg::CMD_W-1:0]    i_command,
    input  logic [eup_pkg::VERTEX_W-1:0] i_vertex_a,
    input  logic [eup_pkg::VERTEX_W-1:0] i_vertex_b,
    input  logic [eup_pkg::VERTEX_W-1:0] i_vertex_count,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output eup_pkg::t_result             o_res
);
    import eup_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEG_A, S_DEG_B, S_WALK, S_RD_DEG, S_CLS_P, S_CLS_R, S_SEND
    } t_state;

    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_VERTICES - 1);

    // Vertex lies inside the store
    function automatic logic in_range(input logic [VERTEX_W-1:0] v);
        in_range = 32'(v) < MAX_VERTICES;
    endfunction

    // Saturating degree bump
    function automatic logic [DEGREE_W-1:0] sat_add(input logic [DEGREE_W-1:0] d,
                                                    input logic [1:0] inc);
        logic [DEGREE_W:0] sum;
        sum = {1'b0, d} + {{(DEGREE_W-1){1'b0}}, inc};
        sat_add = sum[DEGREE_W] ? {DEGREE_W{1'b1}} : sum[DEGREE_W-1:0];
    endfunction

    // Memories
    logic [DEGREE_W-1:0] deg_mem [MAX_VERTICES];
    logic [IDX_W-1:0]    par_mem [MAX_VERTICES];

    logic [IDX_W-1:0]    deg_raddr, deg_waddr, par_raddr, par_waddr, par_wdata;
    logic                deg_we, par_we;
    logic [DEGREE_W-1:0] deg_wdata;
    logic [DEGREE_W-1:0] r_deg_q;
    logic [IDX_W-1:0]    r_par_q;

    // Control and working registers
    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_a, n_a, r_b, n_b, r_cur, n_cur, r_ra, n_ra;
    logic [IDX_W-1:0] r_v, n_v, r_home, n_home;
    logic             r_self, n_self, r_a_ok, n_a_ok, r_phase, n_phase, r_fail, n_fail;
    logic [1:0]       r_odd, n_odd;
    t_result          r_res, n_res;

    // Classify step values
    logic [IDX_W-1:0] cls_home;
    logic             cls_fail;
    logic [1:0]       cls_odd;

    // Degree memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        r_deg_q <= deg_mem[deg_raddr];
    end

    // Parent memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (par_we) begin
            par_mem[par_waddr] <= par_wdata;
        end
        r_par_q <= par_mem[par_raddr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_SEND);
    assign o_res       = r_res;

    // Classify step: root of this vertex is the parent of its parent
    always_comb begin
        cls_home = (r_v == IDX_ONE) ? r_par_q : r_home;
        cls_fail = r_fail | (r_par_q != cls_home);
        cls_odd  = (r_deg_q[0] && r_odd != 2'd3) ? r_odd + 2'd1 : r_odd;
    end

    // Next-state logic
    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_cur   = r_cur;
        n_ra    = r_ra;
        n_v     = r_v;
        n_home  = r_home;
        n_self  = r_self;
        n_a_ok  = r_a_ok;
        n_phase = r_phase;
        n_fail  = r_fail;
        n_odd   = r_odd;
        n_res   = r_res;

        deg_raddr = r_a;
        deg_we    = 1'b0;
        deg_waddr = r_a;
        deg_wdata = '0;
        par_raddr = r_cur;
        par_we    = 1'b0;
        par_waddr = r_cur;
        par_wdata = r_cur;

        case (r_state)
            // Sweep both stores to their reset contents
            S_CLEAR: begin
                deg_we    = 1'b1;
                deg_waddr = r_v;
                deg_wdata = '0;
                par_we    = 1'b1;
                par_waddr = r_v;
                par_wdata = r_v;
                if (r_v == IDX_LAST) begin
                    n_v     = '0;
                    n_state = S_IDLE;
                end else begin
                    n_v = r_v + IDX_ONE;
                end
            end

            // Take a transfer; reads for the first step go out now
            S_IDLE: begin
                deg_raddr = IDX_W'(i_vertex_a);
                par_raddr = IDX_ONE;
                if (i_in_valid) begin
                    n_a    = IDX_W'(i_vertex_a);
                    n_b    = IDX_W'(i_vertex_b);
                    n_self = (i_vertex_a == i_vertex_b);
                    n_a_ok = in_range(i_vertex_a);
                    case (i_command)
                        CMD_ADD_EDGE: begin
                            if (in_range(i_vertex_a) && in_range(i_vertex_b)) begin
                                n_state = S_DEG_A;
                            end
                        end
                        CMD_CLASSIFY: begin
                            n_v    = IDX_ONE;
                            n_fail = 1'b0;
                            n_odd  = 2'd0;
                            if (i_vertex_count == '0) begin
                                n_res   = '{kind: KIND_CLASS, graph_class: CLASS_EULER,
                                            degree: '0};
                                n_state = S_SEND;
                            end else if (!in_range(i_vertex_count)) begin
                                n_res   = '{kind: KIND_CLASS, graph_class: CLASS_NON,
                                            degree: '0};
                                n_state = S_SEND;
                            end else begin
                                n_state = S_CLS_P;
                            end
                        end
                        CMD_READ_DEGREE: begin
                            n_state = S_RD_DEG;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Bump degree of a (self loop adds two and ends here)
            S_DEG_A: begin
                deg_we    = 1'b1;
                deg_waddr = r_a;
                deg_wdata = sat_add(r_deg_q, r_self ? 2'd2 : 2'd1);
                deg_raddr = r_b;
                n_state   = r_self ? S_IDLE : S_DEG_B;
            end

            // Bump degree of b, start the root walk at a
            S_DEG_B: begin
                deg_we    = 1'b1;
                deg_waddr = r_b;
                deg_wdata = sat_add(r_deg_q, 2'd1);
                par_raddr = r_a;
                n_cur     = r_a;
                n_phase   = 1'b0;
                n_state   = S_WALK;
            end

            // Follow parent links to the root of a, then of b, then merge
            S_WALK: begin
                if (r_par_q == r_cur) begin
                    if (!r_phase) begin
                        n_ra      = r_cur;
                        n_cur     = r_b;
                        n_phase   = 1'b1;
                        par_raddr = r_b;
                    end else begin
                        // smaller root becomes the parent of the larger one
                        par_we    = (r_ra != r_cur);
                        par_waddr = (r_ra < r_cur) ? r_cur : r_ra;
                        par_wdata = (r_ra < r_cur) ? r_ra : r_cur;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_cur     = r_par_q;
                    par_raddr = r_par_q;
                end
            end

            // Degree read result
            S_RD_DEG: begin
                n_res   = '{kind: KIND_DEGREE, graph_class: CLASS_NON,
                            degree: r_a_ok ? r_deg_q : '0};
                n_state = S_SEND;
            end

            // Parent of v is here: fetch its parent and v's degree
            S_CLS_P: begin
                par_raddr = r_par_q;
                deg_raddr = r_v;
                n_state   = S_CLS_R;
            end

            // Root of v is here: compress, compare, count odd degree
            S_CLS_R: begin
                par_we    = 1'b1;
                par_waddr = r_v;
                par_wdata = r_par_q;
                n_home    = cls_home;
                n_fail    = cls_fail;
                n_odd     = cls_odd;
                if (32'(r_v) == 32'(i_vertex_count)) begin
                    n_res.kind   = KIND_CLASS;
                    n_res.degree = '0;
                    if (cls_fail) begin
                        n_res.graph_class = CLASS_NON;
                    end else if (cls_odd == 2'd0) begin
                        n_res.graph_class = CLASS_EULER;
                    end else if (cls_odd == 2'd2) begin
                        n_res.graph_class = CLASS_SEMI;
                    end else begin
                        n_res.graph_class = CLASS_NON;
                    end
                    n_state = S_SEND;
                end else begin
                    n_v       = r_v + IDX_ONE;
                    par_raddr = r_v + IDX_ONE;
                    n_state   = S_CLS_P;
                end
            end

            // Hand the result to the output register
            S_SEND: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_v     <= '0;
        end else begin
            r_state <= n_state;
            r_v     <= n_v;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_cur   <= n_cur;
        r_ra    <= n_ra;
        r_home  <= n_home;
        r_self  <= n_self;
        r_a_ok  <= n_a_ok;
        r_phase <= n_phase;
        r_fail  <= n_fail;
        r_odd   <= n_odd;
        r_res   <= n_res;
    end

endmodule

[rtl/euler_path_classifier.sv]
// Euler path classifier top level: configuration register, core, output register.
// Edges come in one transfer at a time; the block keeps a degree count and a
// parent link per vertex in two one-port-read memories and answers classify and
// degree-read commands. After reset a clearing pass over every address fills both
// memories and holds o_in_stall high (configuration writes still work). An add
// edge bumps both degrees, then follows parent links from each endpoint to its
// root, one link per read of the parent memory's single read port (a self loop
// only bumps the degree of a). A classify makes two dependent parent reads per
// vertex and flattens parent chains as it goes so later walks stay short. Results
// land in an output register, so a new transfer is taken while the previous
// result still waits on o_out_valid.
module euler_path_classifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [eup_pkg::CMD_W-1:0]    i_command,
    input  logic [eup_pkg::VERTEX_W-1:0] i_vertex_a,
    input  logic [eup_pkg::VERTEX_W-1:0] i_vertex_b,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_result_kind,
    output logic [eup_pkg::CLASS_W-1:0]  o_graph_class,
    output logic [eup_pkg::DEGREE_W-1:0] o_vertex_degree,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [eup_pkg::PADDR_W-1:0]  paddr,
    input  logic [eup_pkg::PDATA_W-1:0]  pwdata,
    output logic [eup_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import eup_pkg::*;

    logic [VERTEX_W-1:0] r_vertex_count;
    logic                cfg_sel, cfg_wr;
    logic                res_valid, res_ready;
    t_result             res;
    logic                r_out_valid;
    t_result             r_out;

    // Register decode
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
    assign prdata  = cfg_sel ? PDATA_W'(r_vertex_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (cfg_wr) begin
            r_vertex_count <= pwdata[VERTEX_W-1:0];
        end
    end

    eup_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_vertex_a     (i_vertex_a),
        .i_vertex_b     (i_vertex_b),
        .i_vertex_count (r_vertex_count),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // Output register: loads when empty or when its transfer completes
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out.kind;
    assign o_graph_class   = r_out.graph_class;
    assign o_vertex_degree = r_out.degree;

endmodule

[rtl/eup_checker.sv]
// Port-level checker for the Euler path classifier, bound to the top level.
`include "euler_path_classifier_macros.svh"

module eup_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic [eup_pkg::CMD_W-1:0]    i_command,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_result_kind,
    input logic [eup_pkg::CLASS_W-1:0]  o_graph_class,
    input logic [eup_pkg::DEGREE_W-1:0] o_vertex_degree
);
    import eup_pkg::*;

    // Degree results carry no class
    `EPC_ASSERT_IMPL(a_degree_no_class, o_out_valid && o_result_kind == KIND_DEGREE, o_graph_class == CLASS_NON)

    // Classification results carry a real class and no degree
    `EPC_ASSERT_IMPL(a_class_clean, o_out_valid && o_result_kind == KIND_CLASS, o_vertex_degree == '0 && (o_graph_class == CLASS_NON || o_graph_class == CLASS_SEMI || o_graph_class == CLASS_EULER))

    // A command that answers keeps the input side busy the next cycle
    `EPC_ASSERT_NEXT(a_reply_busy, i_in_valid && !o_in_stall && (i_command == CMD_CLASSIFY || i_command == CMD_READ_DEGREE), o_in_stall)

    // A stalled result holds
    `EPC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_result_kind) && $stable(o_graph_class) && $stable(o_vertex_degree))

endmodule

bind euler_path_classifier eup_checker u_checker (.*);

[test/tb.sv]
// Testbench for the Euler path classifier: graph traffic checked against an in-bench predictor.
`timescale 1ns / 1ps

module tb;
    import eup_pkg::*;

    // An add edge can walk two long parent chains and gives no result to wait on
    localparam int SETTLE_CYCLES  = 1100;
    localparam int WATCHDOG_LIMIT = 20000;
    // Receiver hold-off: starts at this result count, lasts this many cycles
    localparam int HOLD_AT        = 40;
    localparam int HOLD_CYCLES    = 300;
    // Vertex hit by a run of back-to-back self loops, kept above the small vertex counts
    localparam int LOOP_VERTEX    = 500;
    localparam int TOP_VERTEX     = MAX_VERTICES - 1;
    localparam logic [PADDR_W-1:0] VCOUNT_ADDR = PADDR_W'(4 * int'(REG_VERTEX_COUNT));
    localparam logic [CMD_W-1:0]   CMD_UNUSED  = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [VERTEX_W-1:0] a;
        logic [VERTEX_W-1:0] b;
        int                  gap;
    } t_graph_op;

    // Block ports
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_in_valid      = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command       = '0;
    logic [VERTEX_W-1:0] i_vertex_a      = '0;
    logic [VERTEX_W-1:0] i_vertex_b      = '0;
    logic                o_out_valid;
    logic                i_out_stall     = 1'b0;
    logic                o_result_kind;
    logic [CLASS_W-1:0]  o_graph_class;
    logic [DEGREE_W-1:0] o_vertex_degree;
    logic                psel            = 1'b0;
    logic                penable         = 1'b0;
    logic                pwrite          = 1'b0;
    logic [PADDR_W-1:0]  paddr           = '0;
    logic [PDATA_W-1:0]  pwdata          = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predicted graph state
    logic [DEGREE_W-1:0] degree_model [MAX_VERTICES];
    logic [VERTEX_W-1:0] parent_model [MAX_VERTICES];
    logic [VERTEX_W-1:0] vcount_model;
    t_result             answer_q [$];

    // Stimulus side
    t_graph_op op_q [$];
    t_graph_op next_op;
    bit        odd_seen [MAX_VERTICES];
    int        queued_ops  = 0;
    int        in_gap_max  = 12;
    int        out_gap_max = 12;
    int        fail_count  = 0;

    always #5 i_clk = ~i_clk;

    euler_path_classifier uut (.*);

    // Predictor
    function automatic logic [VERTEX_W-1:0] find_root(input logic [VERTEX_W-1:0] v);
        logic [VERTEX_W-1:0] r;
        int                  steps;
        r = v;
        steps = 0;
        while (parent_model[r] != r && steps < MAX_VERTICES) begin
            r = parent_model[r];
            steps++;
        end
        return r;
    endfunction

    function automatic void grow_degree(input logic [VERTEX_W-1:0] v, input int amount);
        int sum;
        sum = int'(degree_model[v]) + amount;
        degree_model[v] = (sum > 65535) ? '1 : DEGREE_W'(sum);
    endfunction

    function automatic logic [CLASS_W-1:0] classify_graph();
        logic [VERTEX_W-1:0] home;
        int                  odd;
        if (vcount_model == 0) return CLASS_EULER;
        home = find_root(VERTEX_W'(1));
        odd = 0;
        for (int v = 1; v <= int'(vcount_model); v++) begin
            if (find_root(VERTEX_W'(v)) != home) return CLASS_NON;
            odd += degree_model[v][0];
        end
        if (odd == 0) return CLASS_EULER;
        return (odd == 2) ? CLASS_SEMI : CLASS_NON;
    endfunction

    function automatic void apply_to_model(input logic [CMD_W-1:0] cmd,
                                           input logic [VERTEX_W-1:0] a,
                                           input logic [VERTEX_W-1:0] b);
        t_result             res;
        logic [VERTEX_W-1:0] ra;
        logic [VERTEX_W-1:0] rb;
        res = '0;
        case (cmd)
            CMD_ADD_EDGE: begin
                if (a == b) begin
                    grow_degree(a, 2);
                end else begin
                    grow_degree(a, 1);
                    grow_degree(b, 1);
                    ra = find_root(a);
                    rb = find_root(b);
                    // smaller root wins
                    if (ra < rb) parent_model[rb] = ra;
                    else if (rb < ra) parent_model[ra] = rb;
                end
            end
            CMD_CLASSIFY: begin
                res.kind = KIND_CLASS;
                res.graph_class = classify_graph();
                answer_q = {answer_q, res};
            end
            CMD_READ_DEGREE: begin
                res.kind = KIND_DEGREE;
                res.degree = degree_model[a];
                answer_q = {answer_q, res};
            end
            default: ;
        endcase
    endfunction

    // Input driver: presents queued transfers, each after its own idle gap
    int idle_run = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) apply_to_model(i_command, i_vertex_a, i_vertex_b);
            if (!i_in_valid || !o_in_stall) begin
                if (op_q.size() != 0 && idle_run >= op_q[0].gap) begin
                    next_op = op_q.pop_front();
                    i_command  <= next_op.cmd;
                    i_vertex_a <= next_op.a;
                    i_vertex_b <= next_op.b;
                    i_in_valid <= 1'b1;
                    idle_run = 0;
                end else begin
                    i_in_valid <= 1'b0;
                    idle_run++;
                end
            end
        end
    end

    // Result monitor: random stalls, one long hold-off, compare with oldest answer
    int stall_left   = 0;
    int hold_left    = 0;
    int results_seen = 0;
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected result: kind %0d class %0d degree %0d",
                             $time, o_result_kind, o_graph_class, o_vertex_degree);
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (o_result_kind !== want.kind || o_graph_class !== want.graph_class ||
                        o_vertex_degree !== want.degree) begin
                        $display("%0t: mismatch: expected kind %0d class %0d degree %0d",
                                 $time, want.kind, want.graph_class, want.degree);
                        $display("%0t:           actual kind %0d class %0d degree %0d",
                                 $time, o_result_kind, o_graph_class, o_vertex_degree);
                        fail_count++;
                    end
                end
                results_seen++;
                stall_left = $urandom_range(out_gap_max, 0);
                if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
            end else if (hold_left != 0) begin
                hold_left--;
            end else if (stall_left != 0) begin
                stall_left--;
            end
            i_out_stall <= (hold_left != 0) || (stall_left != 0);
        end
    end

    // Watchdog on cycles without any transfer
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    // Stimulus helpers
    task automatic queue_op(input logic [CMD_W-1:0] cmd, input int a, input int b);
        t_graph_op op;
        op.cmd = cmd;
        op.a = VERTEX_W'(a);
        op.b = VERTEX_W'(b);
        op.gap = $urandom_range(in_gap_max, 0);
        op_q = {op_q, op};
        if (cmd != CMD_UNUSED) queued_ops++;
        // parity shadow used to steer toward Eulerian shapes
        if (cmd == CMD_ADD_EDGE && op.a != op.b) begin
            odd_seen[op.a] = !odd_seen[op.a];
            odd_seen[op.b] = !odd_seen[op.b];
        end
    endtask

    function automatic int pick_vertex();
        if ($urandom_range(9, 0) == 0) return $urandom_range(TOP_VERTEX, 0);
        return $urandom_range(int'(vcount_model), 0);
    endfunction

    // Walk through random vertices, closed walks keep parity
    task automatic queue_walk(input bit closed);
        int first;
        int prev;
        int nxt;
        first = pick_vertex();
        prev = first;
        repeat ($urandom_range(8, 2)) begin
            nxt = pick_vertex();
            queue_op(CMD_ADD_EDGE, prev, nxt);
            prev = nxt;
        end
        if (closed) queue_op(CMD_ADD_EDGE, prev, first);
        queue_op(CMD_CLASSIFY, $urandom_range(TOP_VERTEX, 0), $urandom_range(TOP_VERTEX, 0));
    endtask

    // Path through all checked vertices in shuffled order
    task automatic queue_span();
        int order [$];
        int j;
        int tmp;
        for (int v = 1; v <= int'(vcount_model); v++) order = {order, v};
        for (int i = order.size() - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 1; i < order.size(); i++) queue_op(CMD_ADD_EDGE, order[i-1], order[i]);
    endtask

    // Pair up odd vertices, leaving keep of them odd, then classify
    task automatic queue_repair(input int keep);
        int odd_list [$];
        for (int v = 1; v <= int'(vcount_model); v++)
            if (odd_seen[v]) odd_list = {odd_list, v};
        for (int i = keep; i + 1 < odd_list.size(); i += 2)
            queue_op(CMD_ADD_EDGE, odd_list[i], odd_list[i+1]);
        queue_op(CMD_CLASSIFY, $urandom_range(TOP_VERTEX, 0), $urandom_range(TOP_VERTEX, 0));
    endtask

    // Wait for all answers, then for any trailing add edge to finish
    task automatic wait_idle();
        do @(negedge i_clk); while (op_q.size() != 0 || i_in_valid || answer_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, then read back
    task automatic write_vertex_count(input int value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VCOUNT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        vcount_model = VERTEX_W'(value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        if (prdata[VERTEX_W-1:0] !== VERTEX_W'(value)) begin
            $display("%0t: vertex count readback: expected %0d, actual %0d",
                     $time, value, prdata[VERTEX_W-1:0]);
            fail_count++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(input int vc, input int ops, input bit span,
                             input int in_max, input int out_max);
        int pick;
        int target;
        int a;
        wait_idle();
        write_vertex_count(vc);
        in_gap_max = in_max;
        out_gap_max = out_max;
        @(negedge i_clk);
        if (span) queue_span();
        target = queued_ops + ops;
        while (queued_ops < target) begin
            pick = $urandom_range(99, 0);
            if (pick < 25) begin
                queue_walk(1'b1);
            end else if (pick < 40) begin
                queue_walk(1'b0);
            end else if (pick < 55) begin
                queue_repair(2 * $urandom_range(1, 0));
            end else if (pick < 72) begin
                repeat ($urandom_range(3, 1))
                    queue_op(CMD_READ_DEGREE, pick_vertex(), $urandom_range(TOP_VERTEX, 0));
            end else if (pick < 85) begin
                // stray edge, sometimes a self loop
                a = pick_vertex();
                queue_op(CMD_ADD_EDGE, a, ($urandom_range(3, 0) == 0) ? a : pick_vertex());
            end else if (pick < 92) begin
                queue_op(CMD_UNUSED, $urandom_range(TOP_VERTEX, 0), $urandom_range(TOP_VERTEX, 0));
            end else begin
                queue_op(CMD_CLASSIFY, $urandom_range(TOP_VERTEX, 0),
                         $urandom_range(TOP_VERTEX, 0));
            end
        end
    endtask

    // Main sequence
    initial begin
        for (int v = 0; v < MAX_VERTICES; v++) begin
            degree_model[v] = '0;
            parent_model[v] = VERTEX_W'(v);
            odd_seen[v] = 1'b0;
        end
        vertex_count_reset: vcount_model = VCOUNT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: single vertex, self loop, vertex zero, top vertex, unused command
        in_gap_max = 3;
        out_gap_max = 3;
        @(negedge i_clk);
        queue_op(CMD_CLASSIFY, TOP_VERTEX, TOP_VERTEX);
        queue_op(CMD_READ_DEGREE, 0, 0);
        queue_op(CMD_ADD_EDGE, 1, 1);
        queue_op(CMD_CLASSIFY, 0, 0);
        queue_op(CMD_UNUSED, TOP_VERTEX, TOP_VERTEX);
        queue_op(CMD_ADD_EDGE, 0, TOP_VERTEX);
        queue_op(CMD_READ_DEGREE, TOP_VERTEX, 0);
        queue_op(CMD_READ_DEGREE, 0, TOP_VERTEX);
        wait_idle();

        // Empty vertex range answers Eulerian
        write_vertex_count(0);
        @(negedge i_clk);
        queue_op(CMD_CLASSIFY, 0, 0);
        wait_idle();

        // Four vertices: disconnected, path, cycle, chords, vertex zero edge
        write_vertex_count(4);
        @(negedge i_clk);
        queue_op(CMD_CLASSIFY, 0, 0);
        queue_op(CMD_ADD_EDGE, 1, 2);
        queue_op(CMD_ADD_EDGE, 2, 3);
        queue_op(CMD_ADD_EDGE, 3, 4);
        queue_op(CMD_CLASSIFY, 0, 0);
        queue_op(CMD_ADD_EDGE, 4, 1);
        queue_op(CMD_CLASSIFY, 0, 0);
        queue_op(CMD_ADD_EDGE, 1, 3);
        queue_op(CMD_CLASSIFY, 0, 0);
        queue_op(CMD_ADD_EDGE, 2, 4);
        queue_op(CMD_CLASSIFY, 0, 0);
        queue_op(CMD_ADD_EDGE, 0, 2);
        queue_op(CMD_CLASSIFY, 0, 0);
        queue_op(CMD_READ_DEGREE, 1, 0);
        wait_idle();

        // Back-to-back self loops on one vertex, then an edge to its neighbor
        in_gap_max = 0;
        out_gap_max = 0;
        @(negedge i_clk);
        repeat (24) queue_op(CMD_ADD_EDGE, LOOP_VERTEX, LOOP_VERTEX);
        queue_op(CMD_READ_DEGREE, LOOP_VERTEX, 0);
        queue_op(CMD_ADD_EDGE, LOOP_VERTEX, LOOP_VERTEX + 1);
        queue_op(CMD_READ_DEGREE, LOOP_VERTEX, 0);
        queue_op(CMD_READ_DEGREE, LOOP_VERTEX + 1, 0);

        // Random phases over several vertex counts and idle mixes
        run_phase(3, 100, 1'b1, 12, 12);
        run_phase(16, 100, 1'b1, 0, 12);
        run_phase(6, 80, 1'b0, 12, 0);
        run_phase(TOP_VERTEX, 30, 1'b0, 12, 12);
        run_phase(1, 40, 1'b0, 0, 0);
        run_phase(9, 80, 1'b0, 12, 12);
        run_phase(0, 30, 1'b0, 12, 12);
        run_phase(40, 80, 1'b1, 12, 0);
        run_phase(4, 80, 1'b0, 0, 12);
        run_phase(TOP_VERTEX, 30, 1'b0, 0, 0);
        run_phase(12, 80, 1'b1, 12, 12);
        wait_idle();

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/eup_pkg.sv
rtl/eup_core.sv
rtl/euler_path_classifier.sv
rtl/eup_checker.sv
test/tb.sv
